>>> hw/rtl/lph_pkg.sv
// Shared types and constants for the linear-probing hash map.
// No dependencies.
`timescale 1ns / 1ps
package lph_pkg;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int OUT_W      = 3;

  typedef enum logic [OUT_W-1:0] {
    OUT_MISS     = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_INSERTED = 3'd2,
    OUT_UPDATED  = 3'd3,
    OUT_FULL     = 3'd4
  } outcome_t;

  typedef struct packed {
    logic             insert;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] home;
  } item_t;

  typedef struct packed {
    logic  valid;
    logic  full;
  } q_status_t;
endpackage

>>> hw/rtl/lph_front.sv
// Front end: takes request transfers, classifies them and computes the home slot.
// Depends on lph_pkg.
`timescale 1ns / 1ps
module lph_front import lph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value,
  input  q_status_t        q_status,
  output logic             push,
  output item_t            push_item
);
  logic  held;
  item_t item;

  assign push      = held && !q_status.full;
  assign req_stall = held && q_status.full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        held <= 1'b1;
      end else if (push) begin
        held <= 1'b0;
      end
    end
    if (req_valid && !req_stall) begin
      item.insert <= func;
      item.key    <= key;
      item.value  <= value;
      item.home   <= IDX_W'(key % TABLE_SIZE);
    end
  end
endmodule

>>> hw/rtl/lph_queue.sv
// Two-entry queue between the front end and the probe engine.
// Depends on lph_pkg.
`timescale 1ns / 1ps
module lph_queue import lph_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t status
);
  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head         = mem[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
    if (push) mem[wr_ptr] <= push_item;
  end
endmodule

>>> hw/rtl/lph_back.sv
// Probe engine: slot tables, linear probe walk and result register.
// Depends on lph_pkg.
`timescale 1ns / 1ps
module lph_back import lph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            head,
  input  q_status_t        q_status,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [OUT_W-1:0] outcome,
  output logic [VAL_W-1:0] found_value
);
  typedef enum logic {S_IDLE, S_PROBE} state_t;

  state_t           state;
  item_t            cur;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W-1:0] tried;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] occupancy;

  logic [TABLE_SIZE-1:0] slot_used;
  logic [KEY_W-1:0]      slot_key   [TABLE_SIZE];
  logic [VAL_W-1:0]      slot_value [TABLE_SIZE];
  logic                  used_rd;
  logic [KEY_W-1:0]      key_rd;
  logic [VAL_W-1:0]      val_rd;

  logic out_free;
  logic is_empty;
  logic is_match;
  logic is_last;
  logic stop;
  logic done;

  assign out_free = !rsp_valid || !rsp_stall;
  assign pos_inc  = (pos == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos + 1'b1;
  assign is_empty = !used_rd;
  assign is_match = used_rd && (key_rd == cur.key);
  assign is_last  = (tried == IDX_W'(TABLE_SIZE - 1));
  assign stop     = is_empty || is_match || is_last;
  assign done     = (state == S_PROBE) && out_free && stop;
  assign pop      = (state == S_IDLE) && q_status.valid;
  // hold the read on the final slot while the result waits
  assign rd_addr  = (state == S_PROBE) ? (stop ? pos : pos_inc) : head.home;

  always_ff @(posedge clk) begin
    used_rd <= slot_used[rd_addr];
    key_rd  <= slot_key[rd_addr];
    val_rd  <= slot_value[rd_addr];
    if (done && cur.insert && (is_match || is_empty)) begin
      slot_value[pos] <= cur.value;
    end
    if (done && cur.insert && !is_match && is_empty) begin
      slot_key[pos] <= cur.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      slot_used <= '0;
      occupancy <= '0;
    end else begin
      if (!rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= head;
            pos   <= head.home;
            tried <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (done) begin
            rsp_valid   <= 1'b1;
            found_value <= (!cur.insert && is_match) ? val_rd : '0;
            state       <= S_IDLE;
            if (!cur.insert) begin
              if (is_match) begin
                outcome <= OUT_HIT;
              end else begin
                outcome <= OUT_MISS;
              end
            end else if (is_match) begin
              outcome <= OUT_UPDATED;
            end else if (is_empty) begin
              outcome        <= OUT_INSERTED;
              slot_used[pos] <= 1'b1;
              if (occupancy < CNT_W'(TABLE_SIZE)) occupancy <= occupancy + 1'b1;
            end else begin
              outcome <= OUT_FULL;
            end
          end else if (!stop) begin
            pos   <= pos_inc;
            tried <= tried + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/linear_probe_hash_map_unit.sv
// Top level of the linear-probing hash map: front end, queue, probe engine.
// Depends on lph_pkg, lph_front, lph_queue, lph_back.
//
//   channel | signals                       | direction
//   req     | req_valid/req_stall, func/key/value | in
//   rsp     | rsp_valid/rsp_stall, outcome/found_value | out
//
// In the probe engine an item is first popped from the queue, then its walk probes 1..256
// slots, one slot per cycle through the single read port of the memories.
// Synchronous reset clears slot occupancy flags at once; no clearing pass.
// A stalled response holds the engine; the queue keeps taking requests until full.
`timescale 1ns / 1ps
module linear_probe_hash_map_unit import lph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [OUT_W-1:0] outcome,
  output logic [VAL_W-1:0] found_value
);
  q_status_t q_status;
  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     head;

  lph_front u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .func(func), .key(key), .value(value), .q_status(q_status),
    .push(push), .push_item(push_item)
  );

  lph_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .status(q_status)
  );

  lph_back u_back (
    .clk(clk), .rst(rst), .head(head), .q_status(q_status), .pop(pop),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .outcome(outcome), .found_value(found_value)
  );
endmodule

>>> dv/linear_probe_hash_map_unit_tb.sv
// Self-checking testbench for linear_probe_hash_map_unit: directed rows, table fill, random load.
// Depends on lph_pkg and the RTL of linear_probe_hash_map_unit; checks against its own slot model.
`timescale 1ns / 1ps
module linear_probe_hash_map_unit_tb;
  import lph_pkg::*;

  localparam logic FN_LOOKUP = 1'b0;
  localparam logic FN_INSERT = 1'b1;
  localparam int   HOLD_CYCLES = 600;

  typedef struct {
    logic             fn;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    bit               typed;
    outcome_t         oc;
    logic [VAL_W-1:0] fv;
  } dir_row_t;

  typedef struct {
    outcome_t         oc;
    logic [VAL_W-1:0] fv;
  } rsp_exp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic             func = 1'b0;
  logic [KEY_W-1:0] key = '0;
  logic [VAL_W-1:0] value = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [OUT_W-1:0] outcome;
  logic [VAL_W-1:0] found_value;

  linear_probe_hash_map_unit dut (.*);

  // mirror of the slot table
  bit               slot_used_m [TABLE_SIZE];
  logic [KEY_W-1:0] slot_key_m  [TABLE_SIZE];
  logic [VAL_W-1:0] slot_val_m  [TABLE_SIZE];
  int               slots_taken = 0;
  logic [KEY_W-1:0] stored_keys [$];

  rsp_exp_t pending_rsp [$];
  int       err_cnt = 0;
  int       burst_left = 1;
  bit       hold_req = 1'b0;

  dir_row_t dir_rows [] = '{
    '{FN_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, OUT_MISS, 32'h0},
    '{FN_INSERT, 32'h0000_0000, 32'h0000_0000, 1, OUT_INSERTED, 32'h0},
    '{FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, OUT_INSERTED, 32'h0},
    '{FN_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1, OUT_HIT, 32'hFFFF_FFFF},
    '{FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1, OUT_HIT, 32'h0},
    '{FN_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, 1, OUT_UPDATED, 32'h0},
    '{FN_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1, OUT_UPDATED, 32'h0},
    '{FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1, OUT_HIT, 32'h5A5A_5A5A},
    '{FN_INSERT, 32'h0000_0100, 32'h0000_0001, 0, OUT_MISS, 32'h0},
    '{FN_INSERT, 32'h0000_01FF, 32'h0000_0002, 0, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'h0000_01FF, 32'h0000_0000, 0, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'h0000_0200, 32'h0000_0000, 0, OUT_MISS, 32'h0},
    '{FN_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'h8000_0000, 32'h0000_0000, 0, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'hFFFF_FF00, 32'h0000_0000, 0, OUT_MISS, 32'h0},
    '{FN_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 0, OUT_MISS, 32'h0},
    '{FN_LOOKUP, 32'h0000_0100, 32'h0000_0000, 0, OUT_MISS, 32'h0}
  };

  function automatic bit key_stored(input logic [KEY_W-1:0] k);
    foreach (stored_keys[i]) if (stored_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // probe the mirror and apply the operation
  function automatic rsp_exp_t hash_map_access(input logic fn, input logic [KEY_W-1:0] k,
                                               input logic [VAL_W-1:0] v);
    rsp_exp_t         r;
    logic [IDX_W-1:0] pos;
    bit               hit;
    bit               gap;
    pos = k[IDX_W-1:0];
    hit = 1'b0;
    gap = 1'b0;
    r.fv = '0;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (!slot_used_m[pos]) begin
        gap = 1'b1;
        break;
      end
      if (slot_key_m[pos] == k) begin
        hit = 1'b1;
        break;
      end
      pos = pos + 1'b1;
    end
    if (fn == FN_LOOKUP) begin
      r.oc = hit ? OUT_HIT : OUT_MISS;
      if (hit) r.fv = slot_val_m[pos];
    end else if (hit) begin
      slot_val_m[pos] = v;
      r.oc = OUT_UPDATED;
    end else if (gap) begin
      slot_used_m[pos] = 1'b1;
      slot_key_m[pos] = k;
      slot_val_m[pos] = v;
      slots_taken++;
      stored_keys.push_back(k);
      r.oc = OUT_INSERTED;
    end else begin
      r.oc = OUT_FULL;
    end
    return r;
  endfunction

  task automatic offer(input logic fn, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
                       input bit typed = 0, input outcome_t oc = OUT_MISS,
                       input logic [VAL_W-1:0] fv = '0);
    rsp_exp_t r;
    req_valid <= 1'b1;
    func <= fn;
    key <= k;
    value <= v;
    do @(posedge clk); while (req_stall);
    r = hash_map_access(fn, k, v);
    if (typed) begin
      r.oc = oc;
      r.fv = fv;
    end
    pending_rsp.push_back(r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic random_item;
    logic [KEY_W-1:0] k;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick < 4 && stored_keys.size() != 0)
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    else if (pick < 6)
      k = {24'($urandom_range(0, 24'hFF_FFFF)), 8'($urandom_range(0, 7))}
          ^ {24'h0, 8'($urandom_range(0, 1) * 8'hF8)};
    else
      k = $urandom;
    offer(1'($urandom_range(0, 1)), k, $urandom);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // response side: check, then choose next stall
  initial begin
    int hold_cnt;
    int mode;
    int cyc;
    rsp_exp_t e;
    hold_cnt = 0;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected transfer: outcome %0d value %h",
                                      outcome, found_value);
        end else begin
          e = pending_rsp.pop_front();
          if (outcome !== e.oc || found_value !== e.fv) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp outcome %0d value %h, got outcome %0d value %h",
                       e.oc, e.fv, outcome, found_value);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_stall <= 1'b1;
      end else begin
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= $urandom_range(0, 9) < 3;
          default: rsp_stall <= (cyc % 3) == 0;
        endcase
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i])
      offer(dir_rows[i].fn, dir_rows[i].k, dir_rows[i].v, dir_rows[i].typed,
            dir_rows[i].oc, dir_rows[i].fv);
    drain();
    for (int i = 0; i < 550; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 400) drain();
      random_item();
    end
    // fill every remaining slot, then exercise the full table
    while (slots_taken < TABLE_SIZE) begin
      do k = $urandom; while (key_stored(k));
      offer(FN_INSERT, k, $urandom);
    end
    do k = $urandom; while (key_stored(k));
    offer(FN_INSERT, k, $urandom, 1, OUT_FULL, 32'h0);
    offer(FN_LOOKUP, k, $urandom, 1, OUT_MISS, 32'h0);
    offer(FN_INSERT, 32'h0000_0000, 32'hDEAD_BEEF, 1, OUT_UPDATED, 32'h0);
    offer(FN_LOOKUP, 32'h0000_0000, 32'h0, 1, OUT_HIT, 32'hDEAD_BEEF);
    for (int i = 0; i < 800; i++) begin
      if (i == 300) hold_req = 1'b1;
      random_item();
    end
    drain();
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
